// ===== hw/rtl/v3au_pkg.sv =====
package v3au_pkg;

  // word format, signed fixed point
  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_WIDTH  = 31;

  // derived widths of the square root and divider chains
  localparam int SQ_WIDTH      = 2 * WORD_WIDTH;
  localparam int SQRT_STEPS    = WORD_WIDTH;
  localparam int SREM_WIDTH    = WORD_WIDTH + 2;
  localparam int NUM_WIDTH     = WORD_WIDTH + FRAC_BITS;
  localparam int DIV_STEPS     = NUM_WIDTH;
  localparam int LEN_CMP_WIDTH = (WORD_WIDTH > LEN_WIDTH) ? WORD_WIDTH : LEN_WIDTH;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic        [WORD_WIDTH-1:0] uword_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_MAG   = 3'd4,
    OP_NORM  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  // request and response payloads
  typedef struct packed {
    logic [2:0] opcode;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      scalar_in;
  } v3au_in_t;

  typedef struct packed {
    word_t                res_x;
    word_t                res_y;
    word_t                res_z;
    logic [LEN_WIDTH-1:0] length_out;
    status_e              status;
  } v3au_out_t;

  // data carried along the square root chain
  typedef struct packed {
    logic [2:0]  opcode;
    word_t [2:0] vec;
    word_t       scal;
    logic        sat;
  } sq_side_t;

  typedef struct packed {
    logic [SQ_WIDTH-1:0]   rad;
    logic [SREM_WIDTH-1:0] rem;
    uword_t                root;
    sq_side_t              side;
  } sq_state_t;

  // data carried along the divider chain
  typedef struct packed {
    logic [2:0]  opcode;
    word_t [2:0] vec;
    logic [2:0]  neg;
    logic        dz;
    logic        sat;
    uword_t      mag;
  } dv_side_t;

  typedef struct packed {
    uword_t                    dvsr;
    logic [2:0][NUM_WIDTH-1:0] nq;
    uword_t [2:0]              rem;
    dv_side_t                  side;
  } dv_state_t;

endpackage

// ===== hw/rtl/v3au_front.sv =====
module v3au_front import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  v3au_in_t  data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output sq_state_t state_o
);

  localparam logic [SQ_WIDTH-1:0] SC_POS_LIM = SQ_WIDTH'(uword_t'(WORD_MAX));
  localparam logic [SQ_WIDTH-1:0] SC_NEG_LIM = SC_POS_LIM + SQ_WIDTH'(1);

  word_t                       a_in [3];
  word_t                       b_in [3];
  logic [SQ_WIDTH-1:0]         sq_d [3];
  logic signed [SQ_WIDTH-1:0]  prod_d [3];
  logic signed [WORD_WIDTH:0]  sum_d [3];

  logic                        a_valid_q;
  logic [2:0]                  op_q;
  word_t                       a_q [3];
  word_t                       s_q;
  logic [SQ_WIDTH-1:0]         sq_q [3];
  logic signed [SQ_WIDTH-1:0]  prod_q [3];
  logic signed [WORD_WIDTH:0]  sum_q [3];
  logic                        a_ready;

  logic [SQ_WIDTH-1:0]         sumsq;
  logic [SQ_WIDTH-1:0]         pmag [3];
  logic [SQ_WIDTH-1:0]         psh [3];
  logic [2:0]                  sc_sat;
  logic [2:0]                  as_sat;
  word_t                       sc_res [3];
  word_t                       as_res [3];
  sq_state_t                   st_d;
  logic                        b_valid_q;
  sq_state_t                   st_q;
  logic                        b_ready;

  assign a_in[0] = data_i.a_x;
  assign a_in[1] = data_i.a_y;
  assign a_in[2] = data_i.a_z;
  assign b_in[0] = data_i.b_x;
  assign b_in[1] = data_i.b_y;
  assign b_in[2] = data_i.b_z;

  // handshake of both stages
  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign state_o = st_q;

  // squares, products with the scalar, sums and differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i]   = SQ_WIDTH'(SQ_WIDTH'(a_in[i]) * SQ_WIDTH'(a_in[i]));
      prod_d[i] = SQ_WIDTH'(a_in[i]) * SQ_WIDTH'(data_i.scalar_in);
      if (data_i.opcode == OP_SUB) begin
        sum_d[i] = (WORD_WIDTH+1)'(a_in[i]) - (WORD_WIDTH+1)'(b_in[i]);
      end else begin
        sum_d[i] = (WORD_WIDTH+1)'(a_in[i]) + (WORD_WIDTH+1)'(b_in[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      op_q   <= data_i.opcode;
      a_q    <= a_in;
      s_q    <= data_i.scalar_in;
      sq_q   <= sq_d;
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  // sum of squares, saturation of the early results
  always_comb begin
    sumsq = sq_q[0] + sq_q[1] + sq_q[2];
    for (int i = 0; i < 3; i++) begin
      pmag[i] = prod_q[i][SQ_WIDTH-1] ? -prod_q[i] : prod_q[i];
      psh[i]  = pmag[i] >> FRAC_BITS;
      if (prod_q[i][SQ_WIDTH-1]) begin
        sc_sat[i] = psh[i] > SC_NEG_LIM;
        sc_res[i] = sc_sat[i] ? WORD_MIN : -word_t'(psh[i][WORD_WIDTH-1:0]);
      end else begin
        sc_sat[i] = psh[i] > SC_POS_LIM;
        sc_res[i] = sc_sat[i] ? WORD_MAX : word_t'(psh[i][WORD_WIDTH-1:0]);
      end
      as_sat[i] = sum_q[i][WORD_WIDTH] != sum_q[i][WORD_WIDTH-1];
      if (as_sat[i]) begin
        as_res[i] = sum_q[i][WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      end else begin
        as_res[i] = word_t'(sum_q[i][WORD_WIDTH-1:0]);
      end
    end

    st_d.rad         = sumsq;
    st_d.rem         = '0;
    st_d.root        = '0;
    st_d.side.opcode = op_q;
    st_d.side.scal   = s_q;
    st_d.side.sat    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      st_d.side.vec[i] = a_q[i];
    end
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      for (int i = 0; i < 3; i++) begin
        st_d.side.vec[i] = as_res[i];
      end
      st_d.side.sat = |as_sat;
    end else if (op_q == OP_SCALE) begin
      for (int i = 0; i < 3; i++) begin
        st_d.side.vec[i] = sc_res[i];
      end
      st_d.side.sat = |sc_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== hw/rtl/v3au_sqrt_cell.sv =====
module v3au_sqrt_cell import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  sq_state_t state_i,
  output logic      valid_o,
  input  logic      ready_i,
  output sq_state_t state_o
);

  logic [SREM_WIDTH-1:0] rem_sh;
  logic [SREM_WIDTH-1:0] trial;
  logic [SREM_WIDTH-1:0] diff;
  logic                  fits;
  sq_state_t             st_d;
  logic                  valid_q;
  sq_state_t             st_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign state_o = st_q;

  // one root digit: bring down two radicand bits and try the new digit
  always_comb begin
    rem_sh    = {state_i.rem[SREM_WIDTH-3:0], state_i.rad[SQ_WIDTH-1 -: 2]};
    trial     = {state_i.root, 2'b01};
    fits      = rem_sh >= trial;
    diff      = rem_sh - trial;
    st_d      = state_i;
    st_d.rad  = {state_i.rad[SQ_WIDTH-3:0], 2'b00};
    st_d.rem  = fits ? diff : rem_sh;
    st_d.root = {state_i.root[WORD_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== hw/rtl/v3au_prep.sv =====
module v3au_prep import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  sq_state_t state_i,
  output logic      valid_o,
  input  logic      ready_i,
  output dv_state_t state_o
);

  uword_t    abs_a [3];
  uword_t    abs_s;
  logic      is_div;
  logic      is_norm;
  dv_state_t st_d;
  logic      valid_q;
  dv_state_t st_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign state_o = st_q;

  // divisor, numerators and signs for divide and normalize
  always_comb begin
    is_div  = state_i.side.opcode == OP_DIV;
    is_norm = state_i.side.opcode == OP_NORM;
    abs_s   = state_i.side.scal[WORD_WIDTH-1] ? -uword_t'(state_i.side.scal)
                                              : uword_t'(state_i.side.scal);
    st_d.dvsr = is_norm ? state_i.root : abs_s;
    for (int i = 0; i < 3; i++) begin
      abs_a[i] = state_i.side.vec[i][WORD_WIDTH-1] ? -uword_t'(state_i.side.vec[i])
                                                   : uword_t'(state_i.side.vec[i]);
      st_d.nq[i]       = {abs_a[i], {FRAC_BITS{1'b0}}};
      st_d.rem[i]      = '0;
      st_d.side.neg[i] = is_norm ? state_i.side.vec[i][WORD_WIDTH-1]
                                 : state_i.side.vec[i][WORD_WIDTH-1]
                                   ^ state_i.side.scal[WORD_WIDTH-1];
    end
    st_d.side.opcode = state_i.side.opcode;
    st_d.side.vec    = state_i.side.vec;
    st_d.side.dz     = (is_div && state_i.side.scal == '0) || (is_norm && state_i.root == '0);
    st_d.side.sat    = state_i.side.sat;
    st_d.side.mag    = state_i.root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== hw/rtl/v3au_div_cell.sv =====
module v3au_div_cell import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  dv_state_t state_i,
  output logic      valid_o,
  input  logic      ready_i,
  output dv_state_t state_o
);

  logic [WORD_WIDTH:0] rem_sh [3];
  logic [WORD_WIDTH:0] diff [3];
  logic [2:0]          fits;
  dv_state_t           st_d;
  logic                valid_q;
  dv_state_t           st_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign state_o = st_q;

  // one restoring quotient bit for each component
  always_comb begin
    st_d = state_i;
    for (int i = 0; i < 3; i++) begin
      rem_sh[i]   = {state_i.rem[i], state_i.nq[i][NUM_WIDTH-1]};
      fits[i]     = rem_sh[i] >= {1'b0, state_i.dvsr};
      diff[i]     = rem_sh[i] - {1'b0, state_i.dvsr};
      st_d.rem[i] = fits[i] ? diff[i][WORD_WIDTH-1:0] : rem_sh[i][WORD_WIDTH-1:0];
      st_d.nq[i]  = {state_i.nq[i][NUM_WIDTH-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== hw/rtl/v3au_back.sv =====
module v3au_back import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  dv_state_t state_i,
  output logic      valid_o,
  input  logic      ready_i,
  output v3au_out_t data_o
);

  localparam logic [NUM_WIDTH-1:0] Q_POS_LIM = NUM_WIDTH'(uword_t'(WORD_MAX));
  localparam logic [NUM_WIDTH-1:0] Q_NEG_LIM = Q_POS_LIM + NUM_WIDTH'(1);

  logic [2:0]               q_sat;
  word_t                    q_res [3];
  word_t                    dz_res [3];
  word_t                    res [3];
  logic                     sat;
  logic [LEN_CMP_WIDTH-1:0] mag_ext;
  logic                     len_sat;
  v3au_out_t                out_d;
  logic                     valid_q;
  v3au_out_t                out_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = out_q;

  // quotient saturation and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_i.side.neg[i]) begin
        q_sat[i] = state_i.nq[i] > Q_NEG_LIM;
        q_res[i] = q_sat[i] ? WORD_MIN : -word_t'(state_i.nq[i][WORD_WIDTH-1:0]);
      end else begin
        q_sat[i] = state_i.nq[i] > Q_POS_LIM;
        q_res[i] = q_sat[i] ? WORD_MAX : word_t'(state_i.nq[i][WORD_WIDTH-1:0]);
      end
      // zero divisor: push each component toward its own sign
      if (state_i.side.vec[i] == '0) begin
        dz_res[i] = '0;
      end else begin
        dz_res[i] = state_i.side.vec[i][WORD_WIDTH-1] ? WORD_MIN : WORD_MAX;
      end
    end
  end

  // result select, length and status
  always_comb begin
    mag_ext = LEN_CMP_WIDTH'(state_i.side.mag);
    len_sat = mag_ext > LEN_CMP_WIDTH'(LEN_MAX);
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    sat = 1'b0;
    case (op_e'(state_i.side.opcode))
      OP_ADD, OP_SUB, OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = state_i.side.vec[i];
        end
        sat = state_i.side.sat;
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = state_i.side.dz ? dz_res[i] : q_res[i];
        end
        sat = |q_sat;
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          res[i] = state_i.side.dz ? word_t'('0) : q_res[i];
        end
        sat = |q_sat;
      end
      OP_MAG: begin
        sat = len_sat;
      end
      default: begin
        sat = 1'b0;
      end
    endcase
    out_d.res_x      = res[0];
    out_d.res_y      = res[1];
    out_d.res_z      = res[2];
    out_d.length_out = len_sat ? LEN_MAX : mag_ext[LEN_WIDTH-1:0];
    if (state_i.side.dz) begin
      out_d.status = ST_DIV_ZERO;
    end else if (sat) begin
      out_d.status = ST_SAT;
    end else begin
      out_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/vector3_arithmetic_unit.sv =====
// Three-component vector arithmetic unit, signed Q16.16, no state.
// Input channel: in_valid_i / in_ready_o carry one request in in_data_i
// (opcode, vectors a and b, scalar). Output channel: out_valid_o /
// out_ready_i carry one response in out_data_o (result vector, length of a,
// status). Every request gives exactly one response, in order.
// 84 register stages: two front stages (squares, products, sums),
// one cell per root bit (32), one divider setup stage, one cell per quotient
// bit (48) and the output register.
// Throughput: one request per cycle; the square root and the three
// dividers are unrolled into chains of cells, each cell one bit step.
// Every cell has its own valid bit and a ready taken from its successor,
// so bubbles close up: while the receiver stalls, requests are still taken
// until every stage holds one. in_ready_o only drops when the output
// register holds a response and out_ready_i is low.
// Reset clears the valid bits only; the block is ready right after reset.
module vector3_arithmetic_unit import v3au_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  v3au_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output v3au_out_t out_data_o
);

  logic      sq_valid [SQRT_STEPS+1];
  logic      sq_ready [SQRT_STEPS+1];
  sq_state_t sq_state [SQRT_STEPS+1];
  logic      dv_valid [DIV_STEPS+1];
  logic      dv_ready [DIV_STEPS+1];
  dv_state_t dv_state [DIV_STEPS+1];

  // products, squares and early results
  v3au_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (sq_valid[0]),
    .ready_i (sq_ready[0]),
    .state_o (sq_state[0])
  );

  // square root chain, one root bit per cell
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    v3au_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .ready_o (sq_ready[k]),
      .state_i (sq_state[k]),
      .valid_o (sq_valid[k+1]),
      .ready_i (sq_ready[k+1]),
      .state_o (sq_state[k+1])
    );
  end

  // divisor and numerator setup
  v3au_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid[SQRT_STEPS]),
    .ready_o (sq_ready[SQRT_STEPS]),
    .state_i (sq_state[SQRT_STEPS]),
    .valid_o (dv_valid[0]),
    .ready_i (dv_ready[0]),
    .state_o (dv_state[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    v3au_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .ready_o (dv_ready[k]),
      .state_i (dv_state[k]),
      .valid_o (dv_valid[k+1]),
      .ready_i (dv_ready[k+1]),
      .state_o (dv_state[k+1])
    );
  end

  // result select and output register
  v3au_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid[DIV_STEPS]),
    .ready_o (dv_ready[DIV_STEPS]),
    .state_i (dv_state[DIV_STEPS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // input only blocks behind a stalled, full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output side can move");

  // zero divisor results are zero or saturated per component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_DIV_ZERO) |->
      ((out_data_o.res_x == '0 || out_data_o.res_x == WORD_MAX ||
        out_data_o.res_x == WORD_MIN) &&
       (out_data_o.res_y == '0 || out_data_o.res_y == WORD_MAX ||
        out_data_o.res_y == WORD_MIN) &&
       (out_data_o.res_z == '0 || out_data_o.res_z == WORD_MAX ||
        out_data_o.res_z == WORD_MIN)))
    else $error("divide by zero response carries a non-saturated component");

endmodule

// ===== tb/sv/vector3_arithmetic_unit_test.sv =====
module vector3_arithmetic_unit_test;
  import v3au_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam longint L_MAX = 64'sd2147483647;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  v3au_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  v3au_out_t out_data;

  v3au_out_t expected_q[$];
  int        n_errors;
  int        n_sent;
  int        n_checked;
  int        n_dz;
  int        n_sat;
  int        cycle_cnt;
  int        long_gaps_on;

  vector3_arithmetic_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cycle limit reached");
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_word(longint v, ref bit sat);
    if (v > S_MAX) begin
      sat = 1'b1;
      return S_MAX;
    end
    if (v < S_MIN) begin
      sat = 1'b1;
      return S_MIN;
    end
    return v;
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // expected response of the vector unit for one request
  function automatic v3au_out_t vector_result(v3au_in_t req);
    v3au_out_t rsp;
    longint a[3];
    longint b[3];
    longint r[3];
    longint s;
    longint p;
    longint unsigned sumsq;
    longint unsigned mag;
    longint unsigned q;
    bit sat;
    bit dz;
    a[0] = longint'(req.a_x);
    a[1] = longint'(req.a_y);
    a[2] = longint'(req.a_z);
    b[0] = longint'(req.b_x);
    b[1] = longint'(req.b_y);
    b[2] = longint'(req.b_z);
    s = longint'(req.scalar_in);
    sat = 1'b0;
    dz = 1'b0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = 0;
      sumsq += longint'(abs64(a[i])) * longint'(abs64(a[i]));
    end
    mag = floor_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      case (req.opcode)
        OP_ADD: r[i] = clamp_word(a[i] + b[i], sat);
        OP_SUB: r[i] = clamp_word(a[i] - b[i], sat);
        OP_SCALE: begin
          p = a[i] * s;
          q = abs64(p) >> FRAC_BITS;
          r[i] = clamp_word((p < 0) ? -longint'(q) : longint'(q), sat);
        end
        OP_DIV: begin
          if (s == 0) begin
            dz = 1'b1;
            r[i] = (a[i] > 0) ? S_MAX : ((a[i] < 0) ? S_MIN : 0);
          end else begin
            q = (longint'(abs64(a[i])) << FRAC_BITS) / abs64(s);
            r[i] = clamp_word(((a[i] < 0) != (s < 0)) ? -longint'(q) : longint'(q), sat);
          end
        end
        OP_NORM: begin
          if (mag == 0) begin
            dz = 1'b1;
          end else begin
            q = (longint'(abs64(a[i])) << FRAC_BITS) / mag;
            r[i] = clamp_word((a[i] < 0) ? -longint'(q) : longint'(q), sat);
          end
        end
        default: ;
      endcase
    end
    if (req.opcode == OP_MAG && mag > L_MAX) sat = 1'b1;
    rsp.res_x = word_t'(r[0]);
    rsp.res_y = word_t'(r[1]);
    rsp.res_z = word_t'(r[2]);
    rsp.length_out = (mag > L_MAX) ? LEN_MAX : mag[LEN_WIDTH-1:0];
    rsp.status = dz ? ST_DIV_ZERO : (sat ? ST_SAT : ST_OK);
    return rsp;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 || long_gaps_on == 0) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // send one request and note its expected response
  task automatic send_request(v3au_in_t req);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(vector_result(req));
    n_sent++;
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_gaps_on == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) < 65) ||
                        ($urandom_range(0, 99) < 10 && out_ready);
    end
  end

  // response checker
  always @(posedge clk) begin
    v3au_out_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("response with none expected");
        n_errors++;
      end else begin
        exp_rsp = expected_q.pop_front();
        n_checked++;
        if (exp_rsp.status == ST_DIV_ZERO) n_dz++;
        if (exp_rsp.status == ST_SAT) n_sat++;
        if (out_data.res_x !== exp_rsp.res_x) begin
          $error("res_x exp %h got %h", exp_rsp.res_x, out_data.res_x);
          n_errors++;
        end
        if (out_data.res_y !== exp_rsp.res_y) begin
          $error("res_y exp %h got %h", exp_rsp.res_y, out_data.res_y);
          n_errors++;
        end
        if (out_data.res_z !== exp_rsp.res_z) begin
          $error("res_z exp %h got %h", exp_rsp.res_z, out_data.res_z);
          n_errors++;
        end
        if (out_data.length_out !== exp_rsp.length_out) begin
          $error("length_out exp %h got %h", exp_rsp.length_out, out_data.length_out);
          n_errors++;
        end
        if (out_data.status !== exp_rsp.status) begin
          $error("status exp %0d got %0d", exp_rsp.status, out_data.status);
          n_errors++;
        end
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom_range(0, 3)) - 1;
      3: return word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic v3au_in_t make_request(logic [2:0] op, word_t ax, word_t ay,
                                            word_t az, word_t bx, word_t by,
                                            word_t bz, word_t sc);
    v3au_in_t req;
    req.opcode = op;
    req.a_x = ax;
    req.a_y = ay;
    req.a_z = az;
    req.b_x = bx;
    req.b_y = by;
    req.b_z = bz;
    req.scalar_in = sc;
    return req;
  endfunction

  // extremes, every opcode and the special cases
  task automatic test_directed();
    word_t one;
    one = word_t'(32'h10000);
    send_request(make_request(OP_ADD, WORD_MAX, WORD_MIN, one, one, WORD_MIN, -one,
                              0));
    send_request(make_request(OP_SUB, WORD_MIN, WORD_MAX, 0, one, WORD_MIN, 0, 0));
    send_request(make_request(OP_SCALE, one, -one, WORD_MAX, 0, 0, 0, WORD_MAX));
    send_request(make_request(OP_SCALE, WORD_MIN, 3, -3, 0, 0, 0, WORD_MIN));
    send_request(make_request(OP_SCALE, 5, -5, 1, 0, 0, 0, word_t'(32'h8000)));
    // division by zero and by tiny and extreme divisors, signs of each component
    send_request(make_request(OP_DIV, one, -one, 0, 0, 0, 0, 0));
    send_request(make_request(OP_DIV, WORD_MAX, WORD_MIN, 7, 0, 0, 0, 1));
    send_request(make_request(OP_DIV, WORD_MIN, one, -7, 0, 0, 0, -1));
    send_request(make_request(OP_DIV, 7, -7, one, 0, 0, 0, WORD_MIN));
    // magnitude, saturating and not
    send_request(make_request(OP_MAG, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0));
    send_request(make_request(OP_MAG, WORD_MAX, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_MAG, word_t'(3 << 16), word_t'(4 << 16), 0, 0, 0, 0,
                              0));
    // normalise, zero vector, tiny vectors and an extreme vector
    send_request(make_request(OP_NORM, 0, 0, 0, 1, 1, 1, 1));
    send_request(make_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_NORM, -1, 1, -1, 0, 0, 0, 0));
    send_request(make_request(OP_NORM, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, 0, 0));
    // unused opcodes
    send_request(make_request(3'd6, one, one, one, one, one, one, one));
    send_request(make_request(3'd7, WORD_MIN, WORD_MIN, WORD_MIN, -1, -1, -1, -1));
  endtask

  // random requests, biased toward edge values
  task automatic test_random(int count);
    v3au_in_t req;
    for (int k = 0; k < count; k++) begin
      req = make_request(3'($urandom_range(0, 7)), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word());
      if (req.opcode > 3'd5 && $urandom_range(0, 3) != 0)
        req.opcode = 3'($urandom_range(0, 5));
      if (req.opcode == OP_DIV && $urandom_range(0, 9) == 0) req.scalar_in = 0;
      if (req.opcode == OP_NORM && $urandom_range(0, 9) == 0) begin
        req.a_x = 0;
        req.a_y = 0;
        req.a_z = 0;
      end
      send_request(req);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_dz = 0;
    n_sat = 0;
    cycle_cnt = 0;
    long_gaps_on = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // back to back stretch, no idling
    test_random(100);
    long_gaps_on = 1;
    test_random(700);
    wait_drained();
    $display("%0d requests sent, %0d responses checked", n_sent, n_checked);
    $display("%0d divide-by-zero and %0d saturated responses seen", n_dz, n_sat);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
